// ===== design/apd_pkg.sv =====
package apd_pkg;

  localparam int ALT_W    = 24;
  localparam int TIME_W   = 32;
  localparam int H_W      = 25;
  localparam int MARGIN_W = 23;
  localparam int THR_W    = 8;
  localparam int SCORE_OW = 8;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 120;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam logic signed [H_W-1:0] H_MIN = 25'h1000000;
  localparam logic signed [H_W-1:0] H_MAX = 25'h0FFFFFF;
  localparam logic [THR_W-1:0] THR_RESET = 8'd70;

  typedef enum logic [1:0] {
    REG_GROUND,
    REG_MARGIN,
    REG_THRESH,
    REG_MODE
  } apd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPDATE,
    ST_SCAN,
    ST_DECIDE
  } apd_state_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] ground;
    logic [MARGIN_W-1:0]     margin;
    logic [THR_W-1:0]        threshold;
    logic                    level_mode;
  } apd_cfg_t;

  typedef struct packed {
    logic capture;     // take the input request
    logic calc;        // form relative height
    logic update;      // shift window, track peak and lowest
    logic scan;        // one pair comparison
    logic first;       // pair is the first of its stride
    logic stride_end;  // pair is the last of its stride
    logic decide;      // form cues and load result register
  } apd_cmd_t;

endpackage

// ===== design/apd_cfg.sv =====
module apd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apd_pkg::ADDR_W-1:0]  paddr,
  input  logic [apd_pkg::DATA_W-1:0]  pwdata,
  output logic [apd_pkg::DATA_W-1:0]  prdata,
  output apd_pkg::apd_cfg_t           cfg
);
  import apd_pkg::*;

  apd_cfg_t cfg_r;
  apd_reg_t idx;
  logic     wr_en;

  assign idx   = apd_reg_t'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ground     <= '0;
      cfg_r.margin     <= '0;
      cfg_r.threshold  <= THR_RESET;
      cfg_r.level_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GROUND: cfg_r.ground     <= pwdata[ALT_W-1:0];
        REG_MARGIN: cfg_r.margin     <= pwdata[MARGIN_W-1:0];
        REG_THRESH: cfg_r.threshold  <= pwdata[THR_W-1:0];
        REG_MODE:   cfg_r.level_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GROUND: prdata = DATA_W'(cfg_r.ground);
      REG_MARGIN: prdata = DATA_W'(cfg_r.margin);
      REG_THRESH: prdata = DATA_W'(cfg_r.threshold);
      REG_MODE:   prdata = DATA_W'(cfg_r.level_mode);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== design/apd_ctrl.sv =====
module apd_ctrl #(
  parameter int WINDOW = 8,
  parameter int IDX_W  = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output apd_pkg::apd_cmd_t cmd,
  output logic [IDX_W-1:0]  stride,
  output logic [IDX_W-1:0]  rd_idx
);
  import apd_pkg::*;

  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(WINDOW - 1);

  apd_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] s_r, s_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_pair;
  logic             out_free;

  // next j would be j-s; it has a partner only while j >= 2s
  assign last_pair = {1'b0, j_r} < {s_r, 1'b0};
  assign out_free  = !out_valid_r || out_tready;
  assign stride    = s_r;
  assign rd_idx    = j_r - s_r;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SCAN;
      ST_SCAN:   if (last_pair && s_r == TOP_IDX) state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_CALC:   cmd.calc = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.first      = (j_r == TOP_IDX);
        cmd.stride_end = last_pair;
      end
      ST_DECIDE: cmd.decide = out_free;
      default: ;
    endcase
  end

  always_comb begin
    s_nxt = s_r;
    j_nxt = j_r;
    if (state_r == ST_UPDATE) begin
      s_nxt = IDX_W'(1);
      j_nxt = TOP_IDX;
    end else if (state_r == ST_SCAN) begin
      if (last_pair) begin
        s_nxt = s_r + IDX_W'(1);
        j_nxt = TOP_IDX;
      end else begin
        j_nxt = j_r - s_r;
      end
    end
    out_valid_nxt = out_valid_r;
    if (cmd.decide) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/apd_datapath.sv =====
module apd_datapath #(
  parameter int WINDOW = 8,
  parameter int IDX_W  = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  apd_pkg::apd_cmd_t                 cmd,
  input  logic [IDX_W-1:0]                  stride,
  input  logic [IDX_W-1:0]                  rd_idx,
  input  apd_pkg::apd_cfg_t                 cfg,
  input  logic signed [apd_pkg::ALT_W-1:0]  altitude_cm,
  input  logic [apd_pkg::TIME_W-1:0]        time_us,
  input  logic                              external_flag,
  output logic [apd_pkg::OUT_W-1:0]         result
);
  import apd_pkg::*;

  localparam int SCORE_MAX = (WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6;
  localparam int SCORE_W   = $clog2(SCORE_MAX + 1);
  localparam int CMP_W     = (SCORE_W > THR_W) ? SCORE_W : THR_W;
  localparam int BW        = H_W + 2;
  localparam logic [CMP_W-1:0] SAT = CMP_W'((1 << SCORE_OW) - 1);

  logic signed [ALT_W-1:0] alt_r;
  logic [TIME_W-1:0]       time_r;
  logic                    flag_r;
  logic signed [H_W-1:0]   h_r;
  logic signed [H_W-1:0]   win_r [WINDOW];
  logic signed [H_W-1:0]   peak_r;
  logic [TIME_W-1:0]       ptime_r;
  logic signed [H_W-1:0]   low_r;
  logic signed [H_W-1:0]   prev_r;
  logic                    ok_r;
  logic                    alpha_r;
  logic                    fired_r;
  logic [SCORE_W-1:0]      score_r;
  logic [OUT_W-1:0]        result_r;

  logic signed [H_W-1:0]   h_nxt;
  logic signed [H_W-1:0]   cmp_a, cmp_b;
  logic                    ok_acc;
  logic [IDX_W-1:0]        wdist;
  logic [2*IDX_W-1:0]      wsq;
  logic signed [BW-1:0]    limit;
  logic                    beta;
  logic [CMP_W-1:0]        score_ext;
  logic                    cue;
  logic                    apogee;
  logic [SCORE_OW-1:0]     score_out;

  assign h_nxt  = H_W'(alt_r) - H_W'(cfg.ground);

  // each stride opens at the oldest entry; later pairs chain through prev_r
  assign cmp_a  = cmd.first ? win_r[WINDOW-1] : prev_r;
  assign cmp_b  = win_r[rd_idx];
  assign ok_acc = (cmd.first | ok_r) & (cmp_a > cmp_b);
  assign wdist  = IDX_W'(WINDOW) - stride;
  assign wsq    = (2*IDX_W)'(wdist) * (2*IDX_W)'(wdist);

  assign limit     = BW'(peak_r) - $signed(BW'(cfg.margin));
  assign beta      = BW'(h_r) < limit;
  assign score_ext = CMP_W'(score_r);
  assign cue       = alpha_r | beta | flag_r | (score_ext > CMP_W'(cfg.threshold));
  assign apogee    = cfg.level_mode ? cue : (!fired_r & cue);
  assign score_out = (score_ext > SAT) ? SAT[SCORE_OW-1:0] : score_ext[SCORE_OW-1:0];
  assign result    = result_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      alt_r  <= altitude_cm;
      time_r <= time_us;
      flag_r <= external_flag;
    end
    if (cmd.calc) h_r <= h_nxt;
    if (cmd.scan) begin
      prev_r <= cmp_b;
      ok_r   <= ok_acc;
    end
    if (cmd.decide) begin
      result_r <= {1'b0, low_r, ptime_r, peak_r, apogee, score_out,
                   flag_r, beta, alpha_r, h_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) win_r[k] <= '0;
      peak_r  <= H_MIN;
      ptime_r <= '0;
      low_r   <= H_MAX;
      fired_r <= 1'b0;
      score_r <= '0;
      alpha_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        for (int k = WINDOW - 1; k > 0; k--) win_r[k] <= win_r[k-1];
        win_r[0] <= h_r;
        if (h_r > peak_r) begin
          peak_r  <= h_r;
          ptime_r <= time_r;
        end
        if (h_r < low_r) low_r <= h_r;
        score_r <= '0;
      end
      if (cmd.scan && cmd.stride_end) begin
        if (ok_acc) score_r <= score_r + SCORE_W'(wsq);
        if (stride == IDX_W'(1)) alpha_r <= ok_acc;
      end
      if (cmd.decide && !cfg.level_mode && cue) fired_r <= 1'b1;
    end
  end

endmodule

// ===== design/apogee_detector_top.sv =====
// Channel  | Dir | Handshake                      | Payload
// in_      | in  | in_tvalid / in_tready          | in_tdata: altitude, time, flag
// out_     | out | out_tvalid / out_tready        | out_tdata: height, cues, score, peak, lowest
// cfg_     | in  | cfg_psel / cfg_penable, pready | 4 registers at byte address 4*i
//
// An item passes capture, height, update, scan and decide steps; the scan makes P
// pair comparisons, P = sum over s = 1..WINDOW-1 of floor((WINDOW-1)/s) (P = 16 for
// WINDOW = 8), one window comparison a cycle through a single window read port.
// A request is taken only while the sequencer is idle; a finished result may still
// wait in the output register, the next result stalls only in its final step.
// Synchronous active-low reset clears window, peak, lowest, latch and score, and resets config and sequencer.
module apogee_detector_top #(
  parameter int WINDOW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [23:0] altitude_cm, [55:24] time_us, [56] external_flag
  input  logic [apd_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [24:0] height_cm, [25] falling_cue, [26] drop_cue, [27] trigger_cue,
  // [35:28] stride_score, [36] apogee, [61:37] peak_cm, [93:62] peak_time_us,
  // [118:94] lowest_cm
  output logic [apd_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [apd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [apd_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [apd_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import apd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);

  apd_cfg_t         cfg;
  apd_cmd_t         cmd;
  logic [IDX_W-1:0] stride;
  logic [IDX_W-1:0] rd_idx;

  assign cfg_pready = 1'b1;

  apd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  apd_ctrl #(.WINDOW(WINDOW), .IDX_W(IDX_W)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stride     (stride),
    .rd_idx     (rd_idx)
  );

  apd_datapath #(.WINDOW(WINDOW), .IDX_W(IDX_W)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stride        (stride),
    .rd_idx        (rd_idx),
    .cfg           (cfg),
    .altitude_cm   (in_tdata[23:0]),
    .time_us       (in_tdata[55:24]),
    .external_flag (in_tdata[56]),
    .result        (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while sequencer busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before taken");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.calc, cmd.update, cmd.scan, cmd.decide}))
    else $error("more than one datapath step at once");

  a_stride_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (stride != '0) && (32'(stride) < WINDOW)
      && (32'(rd_idx) + 32'(stride) < WINDOW))
    else $error("scan pair outside window");

endmodule
